@@ sv/wmcc_pkg.sv @@
// Shared types and constants for the window multiset cover counter.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package wmcc_pkg;

   localparam int MAX_LEN_DEF  = 4096;
   localparam int ALPHABET_DEF = 26;
   localparam int LETTER_W     = 5;
   localparam int MODE_W       = 2;
   localparam int TOTAL_W      = 24;
   localparam int PAT_W        = 13;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [PAT_W-1:0]   PAT_SAT   = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PATTERN = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TEXT    = 2'd2;

   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_PATTERN,
      OP_TEXT
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [LETTER_W-1:0] letter;
      logic                last;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DROP
   } state_type;

endpackage

@@ sv/window_multiset_cover_counter_unit.sv @@
// A request passes the front register and the queue; the back end handles a clear or
// pattern letter in its idle state, and a text letter that drops k letters off the left
// edge in idle, then scan, then a drop and a scan per dropped letter (one store read and
// one count update each). Each letter is dropped at most once, so k averages at most 1.
// Reset (synchronous, active high) clears the counts, window bounds, total, overflow flag,
// queue and result register; the text store is not cleared and needs no clearing.
`timescale 1ns / 1ps

module window_multiset_cover_counter_unit
   import wmcc_pkg::*;
#(
   parameter int MAX_LEN  = MAX_LEN_DEF,
   parameter int ALPHABET = ALPHABET_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   // request transactions
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [LETTER_W-1:0] req_letter,
   input  logic                req_last,
   // response transactions, one per text letter
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [TOTAL_W-1:0]  rsp_total,
   output logic                rsp_done_res,
   output logic                rsp_overflow
);

   // front to queue
   logic      fq_valid, fq_ready;
   entry_type fq_entry;
   // queue to back end
   logic      qb_valid, qb_ready;
   entry_type qb_entry;

   // Decode the mode and drop unused codes before they take a queue slot.
   wmcc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_mode   (req_mode),
      .req_letter (req_letter),
      .req_last   (req_last),
      .out_valid  (fq_valid),
      .out_ready  (fq_ready),
      .out_entry  (fq_entry)
   );

   // Decouple the front from a back end that is busy scanning the window.
   wmcc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_entry  (fq_entry),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_entry (qb_entry)
   );

   // Carry out entries in order: update counts, store text, advance the left edge,
   // accumulate the total and hold the result until it is taken.
   wmcc_back #(
      .MAX_LEN  (MAX_LEN),
      .ALPHABET (ALPHABET)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (qb_valid),
      .q_ready      (qb_ready),
      .q_entry      (qb_entry),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_total    (rsp_total),
      .rsp_done_res (rsp_done_res),
      .rsp_overflow (rsp_overflow)
   );

endmodule

@@ sv/wmcc_front.sv @@
// Front stage: accepts request transactions, decodes the mode and holds one entry.
// Depends on wmcc_pkg.
`timescale 1ns / 1ps

module wmcc_front
   import wmcc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [LETTER_W-1:0] req_letter,
   input  logic                req_last,
   output logic                out_valid,
   input  logic                out_ready,
   output entry_type           out_entry
);

   logic      hold_valid_ff, hold_valid_in;
   entry_type hold_entry_ff, hold_entry_in;
   logic      keep;
   logic      accept;

   assign req_ready = !reset && (!hold_valid_ff || out_ready);
   assign accept    = req_valid && req_ready;
   assign out_valid = hold_valid_ff;
   assign out_entry = hold_entry_ff;

   always_comb begin
      keep                 = 1'b1;
      hold_entry_in        = hold_entry_ff;
      hold_entry_in.letter = req_letter;
      hold_entry_in.last   = req_last;
      unique case (req_mode)
         MODE_CLEAR:   hold_entry_in.op = OP_CLEAR;
         MODE_PATTERN: hold_entry_in.op = OP_PATTERN;
         MODE_TEXT:    hold_entry_in.op = OP_TEXT;
         default: begin
            // unused mode: drop it here
            hold_entry_in.op = OP_CLEAR;
            keep             = 1'b0;
         end
      endcase
      if (!accept) begin
         hold_entry_in = hold_entry_ff;
      end
      if (accept) begin
         hold_valid_in = keep;
      end else if (out_ready) begin
         hold_valid_in = 1'b0;
      end else begin
         hold_valid_in = hold_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_entry_ff <= hold_entry_in;
   end

endmodule

@@ sv/wmcc_queue.sv @@
// Short entry queue between the front stage and the back end.
// Depends on wmcc_pkg for the entry type and depth.
`timescale 1ns / 1ps

module wmcc_queue
   import wmcc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  entry_type in_entry,
   output logic      out_valid,
   input  logic      out_ready,
   output entry_type out_entry
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   entry_type         slots [QUEUE_DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]     count_ff, count_in;
   logic              push, pop;

   assign in_ready  = (count_ff != NW'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_entry = slots[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slots[wr_ptr_ff] <= in_entry;
      end
   end

endmodule

@@ sv/wmcc_back.sv @@
// Back end: pattern and window counts, text store, left-edge scan and result register.
// Depends on wmcc_pkg.
`timescale 1ns / 1ps

module wmcc_back
   import wmcc_pkg::*;
#(
   parameter int MAX_LEN  = MAX_LEN_DEF,
   parameter int ALPHABET = ALPHABET_DEF
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_ready,
   input  entry_type          q_entry,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [TOTAL_W-1:0] rsp_total,
   output logic               rsp_done_res,
   output logic               rsp_overflow
);

   localparam int LW = $clog2(ALPHABET);
   localparam int XW = LW + LETTER_W;
   localparam int PW = $clog2(MAX_LEN);
   localparam int EW = $clog2(MAX_LEN + 1);
   localparam int DW = $clog2(ALPHABET + 1);
   localparam int CW = (EW > PAT_W) ? EW : PAT_W;

   logic [PAT_W-1:0]    pattern_count_ff [ALPHABET];
   logic [PAT_W-1:0]    pattern_count_in [ALPHABET];
   logic [EW-1:0]       window_count_ff [ALPHABET];
   logic [EW-1:0]       window_count_in [ALPHABET];
   logic [DW-1:0]       distinct_ff, distinct_in;
   logic [DW-1:0]       covered_ff, covered_in;
   logic [EW-1:0]       left_ff, left_in;
   logic [EW-1:0]       right_ff, right_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic                overflowed_ff, overflowed_in;
   logic                last_ff, last_in;
   state_type           state_ff, state_in;

   logic [LETTER_W-1:0] text_store [MAX_LEN];
   logic [LETTER_W-1:0] rd_data_ff;
   logic                mem_we, rd_en;

   logic [XW-1:0]       q_ext, d_ext;
   logic [LW-1:0]       q_idx, d_idx;
   logic                q_in_range, d_in_range;
   logic [PAT_W-1:0]    q_pat, d_pat;
   logic [EW-1:0]       q_win_inc, d_win, d_win_dec;
   logic [TOTAL_W:0]    sum;
   logic                scan_go, slot_free, text_full;

   logic                out_load, out_ovf;
   logic [TOTAL_W-1:0]  out_total;
   logic                rsp_valid_ff;
   logic [TOTAL_W-1:0]  rsp_total_ff;
   logic                rsp_done_ff, rsp_ovf_ff;

   assign q_ext      = XW'(q_entry.letter);
   assign q_idx      = q_ext[LW-1:0];
   assign q_in_range = (q_ext < XW'(ALPHABET));
   assign d_ext      = XW'(rd_data_ff);
   assign d_idx      = d_ext[LW-1:0];
   assign d_in_range = (d_ext < XW'(ALPHABET));

   assign q_pat     = pattern_count_ff[q_idx];
   assign q_win_inc = window_count_ff[q_idx] + EW'(1);
   assign d_pat     = pattern_count_ff[d_idx];
   assign d_win     = window_count_ff[d_idx];
   assign d_win_dec = (d_win != '0) ? d_win - EW'(1) : d_win;

   assign scan_go   = (left_ff < right_ff) && (covered_ff == distinct_ff);
   assign sum       = {1'b0, total_ff} + (TOTAL_W + 1)'(left_ff);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign text_full = overflowed_ff || (right_ff >= EW'(MAX_LEN));

   always_comb begin
      pattern_count_in = pattern_count_ff;
      window_count_in  = window_count_ff;
      distinct_in      = distinct_ff;
      covered_in       = covered_ff;
      left_in          = left_ff;
      right_in         = right_ff;
      total_in         = total_ff;
      overflowed_in    = overflowed_ff;
      last_in          = last_ff;
      state_in         = state_ff;
      q_ready          = 1'b0;
      mem_we           = 1'b0;
      rd_en            = 1'b0;
      out_load         = 1'b0;
      out_total        = total_ff;
      out_ovf          = overflowed_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               unique case (q_entry.op)
                  OP_CLEAR: begin
                     q_ready          = 1'b1;
                     pattern_count_in = '{default: '0};
                     window_count_in  = '{default: '0};
                     distinct_in      = '0;
                     covered_in       = '0;
                     left_in          = '0;
                     right_in         = '0;
                     total_in         = '0;
                     overflowed_in    = 1'b0;
                  end
                  OP_PATTERN: begin
                     q_ready = 1'b1;
                     // late or out-of-range pattern letters are dropped
                     if (q_in_range && right_ff == '0 && !overflowed_ff) begin
                        if (q_pat == '0) begin
                           distinct_in = distinct_ff + DW'(1);
                        end
                        if (q_pat != PAT_SAT) begin
                           pattern_count_in[q_idx] = q_pat + PAT_W'(1);
                        end
                     end
                  end
                  OP_TEXT: begin
                     if (text_full) begin
                        // store full: flag overflow, report the unchanged total
                        if (slot_free) begin
                           q_ready       = 1'b1;
                           overflowed_in = 1'b1;
                           out_load      = 1'b1;
                           out_total     = total_ff;
                           out_ovf       = 1'b1;
                        end
                     end else begin
                        q_ready  = 1'b1;
                        mem_we   = 1'b1;
                        right_in = right_ff + EW'(1);
                        last_in  = q_entry.last;
                        if (q_in_range) begin
                           window_count_in[q_idx] = q_win_inc;
                           if (q_pat != '0 && CW'(q_win_inc) == CW'(q_pat)) begin
                              covered_in = covered_ff + DW'(1);
                           end
                        end
                        state_in = ST_SCAN;
                     end
                  end
                  default: q_ready = 1'b1;
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_go) begin
               rd_en    = 1'b1;
               state_in = ST_DROP;
            end else if (slot_free) begin
               total_in  = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
               out_load  = 1'b1;
               out_total = total_in;
               out_ovf   = overflowed_ff;
               state_in  = ST_IDLE;
            end
         end
         ST_DROP: begin
            if (d_in_range) begin
               window_count_in[d_idx] = d_win_dec;
               if (d_pat != '0 && CW'(d_win_dec) < CW'(d_pat) && covered_ff != '0) begin
                  covered_in = covered_ff - DW'(1);
               end
            end
            left_in  = left_ff + EW'(1);
            state_in = ST_SCAN;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         pattern_count_ff <= '{default: '0};
         window_count_ff  <= '{default: '0};
         distinct_ff      <= '0;
         covered_ff       <= '0;
         left_ff          <= '0;
         right_ff         <= '0;
         total_ff         <= '0;
         overflowed_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         pattern_count_ff <= pattern_count_in;
         window_count_ff  <= window_count_in;
         distinct_ff      <= distinct_in;
         covered_ff       <= covered_in;
         left_ff          <= left_in;
         right_ff         <= right_in;
         total_ff         <= total_in;
         overflowed_ff    <= overflowed_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      last_ff <= last_in;
      if (out_load) begin
         rsp_total_ff <= out_total;
         rsp_done_ff  <= last_ff && (state_ff == ST_SCAN) || q_entry.last && (state_ff == ST_IDLE);
         rsp_ovf_ff   <= out_ovf;
      end
   end

   // text store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         text_store[right_ff[PW-1:0]] <= q_entry.letter;
      end
      if (rd_en) begin
         rd_data_ff <= text_store[left_ff[PW-1:0]];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_total    = rsp_total_ff;
   assign rsp_done_res = rsp_done_ff;
   assign rsp_overflow = rsp_ovf_ff;

endmodule

@@ sv/wmcc_checker.sv @@
// Port-level checks for the window multiset cover counter, bound to the top level.
// Depends on wmcc_pkg and window_multiset_cover_counter_unit.
`timescale 1ns / 1ps

module wmcc_checker
   import wmcc_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic [MODE_W-1:0]   req_mode,
   input logic [LETTER_W-1:0] req_letter,
   input logic                req_last,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [TOTAL_W-1:0]  rsp_total,
   input logic                rsp_done_res,
   input logic                rsp_overflow
);

   // a held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_total) &&
         $stable(rsp_done_res) && $stable(rsp_overflow))
      else $error("response dropped or changed while stalled");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // no response reaches the output too early after reset
   a_reset_latency: assert property (@(posedge clock)
      reset |=> ##1 !rsp_valid)
      else $error("response appeared too early after reset");

   // no request is taken while reset is applied
   a_no_accept_in_reset: assert property (@(posedge clock)
      reset |-> !req_ready)
      else $error("request accepted during reset");

endmodule

bind window_multiset_cover_counter_unit wmcc_checker u_wmcc_checker (.*);

@@ tb/sv/tb_window_multiset_cover_counter_unit.sv @@
// Self-checking testbench for window_multiset_cover_counter_unit: directed table, then
// random letter streams, checked against an in-bench predictor. Depends on wmcc_pkg.
`timescale 1ns / 1ps

module tb_window_multiset_cover_counter_unit;
   import wmcc_pkg::*;

   // Mode 3 has no package name; the block must ignore it.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int DRAIN_CYCLES  = 32;
   localparam int HOLD_CYCLES   = 400;
   localparam int PRINT_CAP     = 100;
   localparam int DIRECTED_ROWS = 25;

   typedef enum int {
      PH_FREE,
      PH_SEND_IDLE,
      PH_RSP_STALL,
      PH_BOTH,
      PH_HOLD
   } traffic_phase_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] total;
      logic               done;
      logic               ovf;
   } cover_result_type;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [LETTER_W-1:0] letter;
      logic                last;
      logic                checked;
      logic [TOTAL_W-1:0]  total;
      logic                done;
      logic                ovf;
   } directed_row_type;

   // Typed-in results only where they follow at a glance: an empty pattern gives
   // n(n+1)/2, and an unmet pattern gives zero. Other rows go to the predictor.
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      // empty pattern after reset: 1, 3, 6, then text continues past last
      '{MODE_TEXT,    5'd0,  1'b0, 1'b1, 24'd1,  1'b0, 1'b0},
      '{MODE_TEXT,    5'd25, 1'b0, 1'b1, 24'd3,  1'b0, 1'b0},
      '{MODE_TEXT,    5'd31, 1'b1, 1'b1, 24'd6,  1'b1, 1'b0},
      '{MODE_UNUSED,  5'd31, 1'b1, 1'b0, 24'd0,  1'b0, 1'b0},
      '{MODE_TEXT,    5'd1,  1'b0, 1'b1, 24'd10, 1'b0, 1'b0},
      // pattern a, b, a plus out-of-range letters that must be dropped
      '{MODE_CLEAR,   5'd0,  1'b0, 1'b0, 24'd0,  1'b0, 1'b0},
      '{MODE_PATTERN, 5'd0,  1'b0, 1'b0, 24'd0,  1'b0, 1'b0},
      '{MODE_PATTERN, 5'd1,  1'b1, 1'b0, 24'd0,  1'b0, 1'b0},
      '{MODE_PATTERN, 5'd0,  1'b0, 1'b0, 24'd0,  1'b0, 1'b0},
      '{MODE_PATTERN, 5'd26, 1'b0, 1'b0, 24'd0,  1'b0, 1'b0},
      '{MODE_PATTERN, 5'd31, 1'b1, 1'b0, 24'd0,  1'b0, 1'b0},
      '{MODE_TEXT,    5'd0,  1'b0, 1'b1, 24'd0,  1'b0, 1'b0},
      '{MODE_TEXT,    5'd1,  1'b0, 1'b1, 24'd0,  1'b0, 1'b0},
      // late pattern letter, then the window closes over the pattern
      '{MODE_PATTERN, 5'd2,  1'b0, 1'b0, 24'd0,  1'b0, 1'b0},
      '{MODE_TEXT,    5'd2,  1'b0, 1'b0, 24'd0,  1'b0, 1'b0},
      '{MODE_TEXT,    5'd0,  1'b0, 1'b0, 24'd0,  1'b0, 1'b0},
      '{MODE_TEXT,    5'd31, 1'b0, 1'b0, 24'd0,  1'b0, 1'b0},
      '{MODE_TEXT,    5'd1,  1'b1, 1'b0, 24'd0,  1'b0, 1'b0},
      '{MODE_CLEAR,   5'd31, 1'b1, 1'b0, 24'd0,  1'b0, 1'b0},
      '{MODE_TEXT,    5'd0,  1'b1, 1'b1, 24'd1,  1'b1, 1'b0},
      '{MODE_CLEAR,   5'd0,  1'b0, 1'b0, 24'd0,  1'b0, 1'b0},
      '{MODE_PATTERN, 5'd25, 1'b0, 1'b0, 24'd0,  1'b0, 1'b0},
      '{MODE_TEXT,    5'd0,  1'b0, 1'b1, 24'd0,  1'b0, 1'b0},
      '{MODE_TEXT,    5'd25, 1'b1, 1'b0, 24'd0,  1'b0, 1'b0},
      '{MODE_UNUSED,  5'd0,  1'b0, 1'b0, 24'd0,  1'b0, 1'b0}
   };

   // Every DUT input starts at a known value.
   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_valid  = 1'b0;
   logic                req_ready;
   logic [MODE_W-1:0]   req_mode   = MODE_CLEAR;
   logic [LETTER_W-1:0] req_letter = '0;
   logic                req_last   = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready  = 1'b0;
   logic [TOTAL_W-1:0]  rsp_total;
   logic                rsp_done_res;
   logic                rsp_overflow;

   window_multiset_cover_counter_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (req_mode),
      .req_letter   (req_letter),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_total    (rsp_total),
      .rsp_done_res (rsp_done_res),
      .rsp_overflow (rsp_overflow)
   );

   // Predictor state: a private copy of the counter's counts, window and total.
   logic [PAT_W-1:0]    pat_cnt  [ALPHABET_DEF];
   logic [PAT_W-1:0]    win_cnt  [ALPHABET_DEF];
   logic [LETTER_W-1:0] text_mem [MAX_LEN_DEF];
   logic [LETTER_W-1:0] need_cnt;
   logic [LETTER_W-1:0] covered_cnt;
   logic [PAT_W-1:0]    left_pos;
   logic [PAT_W-1:0]    right_pos;
   logic [TOTAL_W-1:0]  cover_total;
   logic                text_overflowed;

   cover_result_type  expected_totals [$];
   int                mismatch_count = 0;
   int                items_sent     = 0;
   int                cycle_count    = 0;
   int                send_idle_pct  = 0;
   int                rsp_stall_pct  = 0;
   traffic_phase_type phase          = PH_FREE;
   traffic_phase_type phase_seen     = PH_FREE;
   int                hold_left      = 0;

   // Free-running clock, 8 ns period.
   initial begin
      forever #4 clock = ~clock;
   end

   // Watchdog: end the run with an error once the cycle limit is reached, so a stalled block cannot hang it.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Print one line per mismatch (capped) and count every one.
   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < PRINT_CAP)
         $display("mismatch %s: got %0d, expected %0d (cycle %0d)", what, got, want,
                  cycle_count);
      mismatch_count++;
   endtask

   function automatic void clear_counts();
      for (int k = 0; k < ALPHABET_DEF; k++) begin
         pat_cnt[k] = '0;
         win_cnt[k] = '0;
      end
      need_cnt        = '0;
      covered_cnt     = '0;
      left_pos        = '0;
      right_pos       = '0;
      cover_total     = '0;
      text_overflowed = 1'b0;
   endfunction

   // Advance the predictor by one request; return 1 when a response is due.
   function automatic bit advance_cover(input logic [MODE_W-1:0] mode,
                                        input logic [LETTER_W-1:0] letter,
                                        input logic last,
                                        output cover_result_type res);
      int pos;
      int d;
      int sum;
      res = '0;
      case (mode)
         MODE_CLEAR: begin
            clear_counts();
            return 1'b0;
         end
         MODE_PATTERN: begin
            // Pattern letters count only before any text and while in range.
            if (letter < ALPHABET_DEF && right_pos == 0 && !text_overflowed) begin
               if (pat_cnt[letter] == 0)
                  need_cnt++;
               if (pat_cnt[letter] != PAT_SAT)
                  pat_cnt[letter]++;
            end
            return 1'b0;
         end
         MODE_TEXT: begin
            if (text_overflowed || right_pos >= MAX_LEN_DEF) begin
               // Store full: flag it, keep the total as it is.
               text_overflowed = 1'b1;
            end else begin
               pos = int'(right_pos);
               text_mem[pos] = letter;
               right_pos = PAT_W'(pos + 1);
               if (letter < ALPHABET_DEF) begin
                  win_cnt[letter]++;
                  if (pat_cnt[letter] != 0 && win_cnt[letter] == pat_cnt[letter])
                     covered_cnt++;
               end
               // Shrink the window from the left while it still covers the pattern.
               while (left_pos <= pos && left_pos < MAX_LEN_DEF && covered_cnt == need_cnt)
               begin
                  d = int'(text_mem[left_pos]);
                  if (d < ALPHABET_DEF) begin
                     if (win_cnt[d] != 0)
                        win_cnt[d]--;
                     if (pat_cnt[d] != 0 && win_cnt[d] < pat_cnt[d] && covered_cnt != 0)
                        covered_cnt--;
                  end
                  left_pos++;
               end
               sum = int'(cover_total) + int'(left_pos);
               cover_total = (sum > int'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(sum);
            end
            res.total = cover_total;
            res.done  = last;
            res.ovf   = text_overflowed;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // Offer one request transaction and hold it until accepted. Called at a rising
   // edge; returns at the edge that accepted the transaction.
   task automatic send_request(input logic [MODE_W-1:0] mode,
                               input logic [LETTER_W-1:0] letter,
                               input logic last,
                               input bit typed = 1'b0,
                               input cover_result_type typed_res = '0);
      bit               produced;
      cover_result_type predicted;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid  <= 1'b1;
      req_mode   <= mode;
      req_letter <= letter;
      req_last   <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      produced = advance_cover(mode, letter, last, predicted);
      if (produced)
         expected_totals.push_back(typed ? typed_res : predicted);
      if (mode != MODE_UNUSED)
         items_sent++;
   endtask

   // Drop valid, wait for every expected response, then let the back end settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_totals.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_phase(input traffic_phase_type p);
      phase <= p;
      case (p)
         PH_SEND_IDLE: begin send_idle_pct = 51; rsp_stall_pct <= 0;  end
         PH_RSP_STALL: begin send_idle_pct = 0;  rsp_stall_pct <= 51; end
         PH_BOTH:      begin send_idle_pct = 27; rsp_stall_pct <= 27; end
         default:      begin send_idle_pct = 0;  rsp_stall_pct <= 0;  end
      endcase
   endtask

   // Mostly letters from a small window of the alphabet so patterns get covered;
   // some from anywhere, a few out of range.
   function automatic logic [LETTER_W-1:0] pick_letter(input int base, input int span);
      int r;
      r = $urandom_range(99);
      if (r < 85)
         return LETTER_W'(base + $urandom_range(span - 1));
      else if (r < 95)
         return LETTER_W'($urandom_range(ALPHABET_DEF - 1));
      return LETTER_W'($urandom_range(ALPHABET_DEF, 31));
   endfunction

   // Random traffic: mostly clear / pattern / text sequences, the rest noise.
   task automatic run_random(input int target);
      int first;
      int span;
      int base;
      int pat_len;
      int txt_len;
      first = items_sent;
      while (items_sent - first < target) begin
         span = $urandom_range(1, 4);
         base = $urandom_range(0, ALPHABET_DEF - span);
         if ($urandom_range(99) < 82) begin
            if ($urandom_range(9) < 7)
               send_request(MODE_CLEAR, LETTER_W'($urandom_range(31)),
                            1'($urandom_range(1)));
            pat_len = $urandom_range(0, 5);
            for (int i = 0; i < pat_len; i++)
               send_request(MODE_PATTERN, pick_letter(base, span), 1'($urandom_range(1)));
            txt_len = ($urandom_range(19) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 30);
            for (int i = 0; i < txt_len; i++) begin
               if ($urandom_range(49) == 0)
                  send_request(MODE_UNUSED, LETTER_W'($urandom_range(31)),
                               1'($urandom_range(1)));
               if ($urandom_range(39) == 0)
                  send_request(MODE_PATTERN, pick_letter(base, span),
                               1'($urandom_range(1)));
               send_request(MODE_TEXT, pick_letter(base, span),
                            (i == txt_len - 1) || ($urandom_range(29) == 0));
            end
         end else begin
            repeat ($urandom_range(1, 8))
               send_request(MODE_W'($urandom_range(3)), LETTER_W'($urandom_range(31)),
                            1'($urandom_range(1)));
         end
      end
   endtask

   // Response side: check each accepted transaction against the oldest expectation,
   // then pick the next ready level. A phase change into PH_HOLD starts a long
   // hold-off, counted here, so the block fills and stalls its request side.
   always @(posedge clock) begin : rsp_side
      cover_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_totals.size() == 0) begin
            report_mismatch("unexpected response, total", int'(rsp_total), -1);
         end else begin
            want = expected_totals.pop_front();
            if (rsp_total !== want.total)
               report_mismatch("total", int'(rsp_total), int'(want.total));
            if (rsp_done_res !== want.done)
               report_mismatch("done_res", int'(rsp_done_res), int'(want.done));
            if (rsp_overflow !== want.ovf)
               report_mismatch("overflow", int'(rsp_overflow), int'(want.ovf));
         end
      end
      if (phase != phase_seen) begin
         phase_seen = phase;
         if (phase == PH_HOLD)
            hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Request side: reset, directed table, random phases, long-text and
   // saturation sweeps, then the verdict.
   initial begin
      clear_counts();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_phase(PH_FREE);
      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_request(DIRECTED[i].mode, DIRECTED[i].letter, DIRECTED[i].last,
                      DIRECTED[i].checked,
                      cover_result_type'{DIRECTED[i].total, DIRECTED[i].done,
                                         DIRECTED[i].ovf});
      drain();

      run_random(400);
      drain();
      set_phase(PH_SEND_IDLE);
      run_random(400);
      drain();
      set_phase(PH_HOLD);
      run_random(120);
      drain();
      set_phase(PH_RSP_STALL);
      run_random(400);
      drain();
      set_phase(PH_BOTH);
      run_random(400);
      drain();

      // Fill the text store with an empty pattern, then push past it: the
      // overflow letter keeps the full-store total and raises the flag.
      set_phase(PH_FREE);
      send_request(MODE_CLEAR, 5'd0, 1'b0);
      repeat (MAX_LEN_DEF)
         send_request(MODE_TEXT, LETTER_W'($urandom_range(31)), 1'($urandom_range(1)));
      send_request(MODE_TEXT, 5'd3, 1'b1, 1'b1,
                   cover_result_type'{TOTAL_W'(MAX_LEN_DEF * (MAX_LEN_DEF + 1) / 2),
                                      1'b1, 1'b1});
      send_request(MODE_PATTERN, 5'd4, 1'b0);
      repeat (3)
         send_request(MODE_TEXT, LETTER_W'($urandom_range(31)), 1'($urandom_range(1)));
      send_request(MODE_CLEAR, 5'd0, 1'b0);
      send_request(MODE_TEXT, 5'd7, 1'b1, 1'b1, cover_result_type'{24'd1, 1'b1, 1'b0});
      drain();

      // Drive one pattern count into saturation; the text can then never cover it.
      send_request(MODE_CLEAR, 5'd0, 1'b0);
      repeat (int'(PAT_SAT) + 4)
         send_request(MODE_PATTERN, 5'd16, 1'($urandom_range(1)));
      send_request(MODE_PATTERN, 5'd2, 1'b0);
      repeat (40)
         send_request(MODE_TEXT, ($urandom_range(3) == 0) ? 5'd2 : 5'd16,
                      1'($urandom_range(1)));
      drain();

      if (mismatch_count == 0 && expected_totals.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
